// ----- rtl/rqfs_pkg.sv -----
package rqfs_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned OCC_W   = 5;

  typedef struct packed {
    logic push;
    logic pop;
    logic mode;
  } cell_ctrl_t;

endpackage

// ----- rtl/rqfs_cell.sv -----
module rqfs_cell
  import rqfs_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned KEY_W = 16
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] cnt,
  input  logic [ID_W-1:0]  new_id,
  input  logic [KEY_W-1:0] new_key,
  input  logic             found_in,
  output logic             found_out,
  input  logic [ID_W-1:0]  left_id,
  input  logic [KEY_W-1:0] left_key,
  input  logic [ID_W-1:0]  right_id,
  input  logic [KEY_W-1:0] right_key,
  output logic [ID_W-1:0]  id,
  output logic [KEY_W-1:0] key
);

  logic [ID_W-1:0]  id_r,  id_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             occ;
  logic             ins_here;

  assign occ       = cnt > CNT_W'(IDX);
  assign ins_here  = !found_in && (!occ || (ctrl.mode && (key_r > new_key)));
  assign found_out = found_in || ins_here;

  always_comb begin
    id_nxt  = id_r;
    key_nxt = key_r;
    if (ctrl.push) begin
      if (found_in) begin
        id_nxt  = left_id;
        key_nxt = left_key;
      end else if (ins_here) begin
        id_nxt  = new_id;
        key_nxt = new_key;
      end
    end else if (ctrl.pop) begin
      id_nxt  = right_id;
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    key_r <= key_nxt;
  end

  assign id  = id_r;
  assign key = key_r;

endmodule

// ----- rtl/ready_queue_fifo_or_shortest_first_core.sv -----
// Bounded ready queue of DEPTH entries held in a row of cells, head in cell 0.
// Each command (push, pop, clear) is one transfer on the in_ channel and yields
// one transfer on the out_ channel; one command is taken every clock cycle as
// long as the result register is free or being drained; the result is registered
// and shows in the next cycle. A push in first-in first-out mode appends at the
// tail; in shortest-first mode (order_mode 1) the cells compare their key with
// the new key in parallel and the entry lands after all entries whose key is
// not greater, so equal keys keep arrival order. Entries shift one cell per
// push or pop. A push on a full queue is dropped with status 2; a pop on an
// empty queue returns zeros with status 1. Write order_mode only while idle;
// a mode change leaves held entries in place.
module ready_queue_fifo_or_shortest_first_core
  import rqfs_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_order_mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [ID_W-1:0]    in_proc_id,
  input  logic [BURST_W-1:0] in_burst_left,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_out_valid,
  output logic [ID_W-1:0]    out_id,
  output logic [BURST_W-1:0] out_burst,
  output logic [1:0]         out_status,
  output logic [OCC_W-1:0]   out_occupancy
);

  localparam int unsigned KEY_W = (KEY_WIDTH < BURST_W) ? KEY_WIDTH : BURST_W;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             mode_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic             res_valid_r, res_valid_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  logic [BURST_W-1:0] res_burst_r, res_burst_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [OCC_W-1:0] res_occ_r;

  logic             in_fire;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  logic [KEY_W-1:0] new_key;

  logic [ID_W-1:0]  cell_id  [DEPTH];
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [DEPTH:0]   found;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign full      = count_r == CNT_W'(DEPTH);
  assign empty     = count_r == '0;
  assign new_key   = in_burst_left[KEY_W-1:0];

  assign ctrl.push = in_fire && (in_cmd == CMD_PUSH) && !full;
  assign ctrl.pop  = in_fire && (in_cmd == CMD_POP) && !empty;
  assign ctrl.mode = mode_r;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]  l_id,  r_id;
    logic [KEY_W-1:0] l_key, r_key;
    if (i == 0) begin : g_head
      assign l_id  = '0;
      assign l_key = '0;
    end else begin : g_mid
      assign l_id  = cell_id[i-1];
      assign l_key = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_id  = '0;
      assign r_key = '0;
    end else begin : g_body
      assign r_id  = cell_id[i+1];
      assign r_key = cell_key[i+1];
    end
    rqfs_cell #(
      .IDX   (i),
      .CNT_W (CNT_W),
      .KEY_W (KEY_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cnt       (count_r),
      .new_id    (in_proc_id),
      .new_key   (new_key),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .left_id   (l_id),
      .left_key  (l_key),
      .right_id  (r_id),
      .right_key (r_key),
      .id        (cell_id[i]),
      .key       (cell_key[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    res_valid_nxt  = 1'b0;
    res_id_nxt     = '0;
    res_burst_nxt  = '0;
    res_status_nxt = ST_OK;
    case (in_cmd)
      CMD_PUSH: begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          res_valid_nxt = 1'b1;
          res_id_nxt    = cell_id[0];
          res_burst_nxt = BURST_W'(cell_key[0]);
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_order_mode;
      end
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_valid_r  <= res_valid_nxt;
      res_id_r     <= res_id_nxt;
      res_burst_r  <= res_burst_nxt;
      res_status_r <= res_status_nxt;
      res_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_out_valid = res_valid_r;
  assign out_id        = res_id_r;
  assign out_burst     = res_burst_r;
  assign out_status    = res_status_r;
  assign out_occupancy = res_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == CMD_POP) && !empty |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not remove one entry");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == CMD_PUSH) && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not add one entry");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == CMD_PUSH) |=> (out_status == ST_FULL) == $past(full))
    else $error("full status mismatch");

  a_insert_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> found[DEPTH])
    else $error("push found no insert cell");

endmodule
